@@ design/hrc_pkg.sv @@
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared types and codes for the HID report coalescer.
// ----------------------------------------------------------------------------
package hrc_pkg;

    // event kinds on the input side
    localparam logic [2:0] MODE_ABS     = 3'd0;
    localparam logic [2:0] MODE_REL     = 3'd1;
    localparam logic [2:0] MODE_KEYB    = 3'd2;
    localparam logic [2:0] MODE_CONSUME = 3'd3;
    localparam logic [2:0] MODE_RELEASE = 3'd4;

    // report kinds on the output side
    localparam logic [1:0] KIND_ABS     = 2'd0;
    localparam logic [1:0] KIND_REL     = 2'd1;
    localparam logic [1:0] KIND_KEYB    = 2'd2;
    localparam logic [1:0] KIND_CONSUME = 2'd3;

    localparam int unsigned ABS_WIDTH = 15;
    localparam logic [ABS_WIDTH-1:0] ABS_MAX_RESET = 15'h7fff;

    localparam logic signed [8:0] SCROLL_MAX = 9'sd127;
    localparam logic signed [8:0] SCROLL_MIN = -9'sd127;
    localparam logic signed [15:0] REL_OUT_MAX = 16'sh7fff;
    localparam logic signed [15:0] REL_OUT_MIN = 16'sh8000;

    // maximum reports that one transaction can cause
    localparam int unsigned MAX_REPORTS = 5;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         buttons;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [7:0]  wheel;
        logic signed [7:0]  pan;
        logic [47:0]        keys;
        logic [15:0]        usage;
    } t_report;

    localparam t_report REPORT_ZERO = '0;

endpackage

@@ design/hid_report_coalescer_unit.sv @@
// ----------------------------------------------------------------------------
// hid_report_coalescer_unit
// Coalesces queued HID events into USB reports, merging mouse movement.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  -------   ---------  ---------            -------
//  event     in         i_valid / o_ready    i_mode .. i_host_mounted
//  report    out        o_valid / i_ready    o_report_kind .. o_last_of_run
//  config    in         i_cfg_we             i_cfg_wdata (abs_max)
//
//  An event is held in the input register; its reports (up to five) go
//  into a report list that drains one per cycle while i_ready is high; an
//  event causing at most one report flows at that rate. Release-all and a
//  flush ahead of another report hold the input until the list drains.
//  Synchronous active-low reset clears the pending report, abs_max back to
//  its maximum and both sides idle. Output stalls back up into the input.
//
module hid_report_coalescer_unit #(
    parameter int ACC_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [14:0]        i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_mode,
    input  logic [7:0]         i_buttons_or_modifier,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [7:0]  i_wheel,
    input  logic signed [7:0]  i_pan,
    input  logic [47:0]        i_key_codes,
    input  logic [15:0]        i_usage_code,
    input  logic               i_more_queued,
    input  logic               i_host_mounted,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_report_kind,
    output logic [7:0]         o_out_buttons,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic signed [7:0]  o_out_wheel,
    output logic signed [7:0]  o_out_pan,
    output logic [47:0]        o_out_keys,
    output logic [15:0]        o_out_usage,
    output logic               o_last_of_run
);

    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam int CNT_W = $clog2(hrc_pkg::MAX_REPORTS + 1);

    // ---------------------------------------------------------------- helpers

    function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] a,
                                                     input logic signed [15:0] b);
        logic [ACC_WIDTH:0] sum;
        sum = {a[ACC_WIDTH-1], a} + {{(ACC_WIDTH-15){b[15]}}, b};
        if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
            return sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end
        return sum[ACC_WIDTH-1:0];
    endfunction

    function automatic logic signed [7:0] sat_scroll(input logic signed [7:0] a,
                                                     input logic signed [7:0] b);
        logic signed [8:0] sum;
        sum = {a[7], a} + {b[7], b};
        if (sum > hrc_pkg::SCROLL_MAX) begin
            return hrc_pkg::SCROLL_MAX[7:0];
        end
        if (sum < hrc_pkg::SCROLL_MIN) begin
            return hrc_pkg::SCROLL_MIN[7:0];
        end
        return sum[7:0];
    endfunction

    // accumulator down to 16 bits with saturation
    function automatic logic signed [15:0] clamp16(input logic [ACC_WIDTH-1:0] v);
        logic [ACC_WIDTH-16:0] upper;
        upper = v[ACC_WIDTH-1:15];
        if (v[ACC_WIDTH-1] && !(&upper)) begin
            return hrc_pkg::REL_OUT_MIN;
        end
        if (!v[ACC_WIDTH-1] && (|upper)) begin
            return hrc_pkg::REL_OUT_MAX;
        end
        return v[15:0];
    endfunction

    function automatic hrc_pkg::t_report mouse_report(input logic is_rel,
                                                      input logic [7:0] btn,
                                                      input logic [ACC_WIDTH-1:0] dx,
                                                      input logic [ACC_WIDTH-1:0] dy,
                                                      input logic signed [7:0] wh,
                                                      input logic signed [7:0] pn);
        hrc_pkg::t_report r;
        r         = hrc_pkg::REPORT_ZERO;
        r.kind    = is_rel ? hrc_pkg::KIND_REL : hrc_pkg::KIND_ABS;
        r.buttons = btn;
        r.x       = is_rel ? clamp16(dx) : dx[15:0];
        r.y       = is_rel ? clamp16(dy) : dy[15:0];
        r.wheel   = wh;
        r.pan     = pn;
        return r;
    endfunction

    // ---------------------------------------------------------------- registers

    logic [14:0]        r_abs_max;

    logic               r_in_valid;
    logic [2:0]         r_mode;
    logic [7:0]         r_btn;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [7:0]  r_wh;
    logic signed [7:0]  r_pn;
    logic [47:0]        r_keys;
    logic [15:0]        r_usage;
    logic               r_more;
    logic               r_mounted;

    logic                 r_pend_valid;
    logic                 r_pend_rel;
    logic [7:0]           r_pend_btn;
    logic [ACC_WIDTH-1:0] r_pend_dx;
    logic [ACC_WIDTH-1:0] r_pend_dy;
    logic signed [7:0]    r_pend_wh;
    logic signed [7:0]    r_pend_pn;
    logic [14:0]          r_last_x;
    logic [14:0]          r_last_y;

    logic                 n_pend_valid;
    logic                 n_pend_rel;
    logic [7:0]           n_pend_btn;
    logic [ACC_WIDTH-1:0] n_pend_dx;
    logic [ACC_WIDTH-1:0] n_pend_dy;
    logic signed [7:0]    n_pend_wh;
    logic signed [7:0]    n_pend_pn;
    logic [14:0]          n_last_x;
    logic [14:0]          n_last_y;

    hrc_pkg::t_report     r_list [hrc_pkg::MAX_REPORTS];
    hrc_pkg::t_report     n_list [hrc_pkg::MAX_REPORTS];
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;

    logic take;
    logic list_free;
    logic advance;

    assign take      = o_valid && i_ready;
    assign list_free = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && take);
    assign advance   = r_in_valid && list_free;
    assign o_ready   = !r_in_valid || advance;

    // ---------------------------------------------------------------- event logic

    always_comb begin
        logic                 mouse;
        logic                 merge;
        logic                 flush_old;
        logic [14:0]          ax;
        logic [14:0]          ay;
        logic [ACC_WIDTH-1:0] ex;
        logic [ACC_WIDTH-1:0] ey;
        logic [14:0]          mid_x;
        logic [14:0]          mid_y;
        logic                 has_first;
        hrc_pkg::t_report     first;
        hrc_pkg::t_report     own [4];
        logic [2:0]           own_cnt;

        mouse = (r_mode == hrc_pkg::MODE_ABS) || (r_mode == hrc_pkg::MODE_REL);
        merge = r_pend_valid && mouse && (r_mode[0] == r_pend_rel) && (r_btn == r_pend_btn);
        flush_old = r_pend_valid && !merge;

        ax = ({1'b0, r_abs_max} < r_x) ? r_abs_max : r_x[14:0];
        ay = ({1'b0, r_abs_max} < r_y) ? r_abs_max : r_y[14:0];
        if (r_mode == hrc_pkg::MODE_ABS) begin
            ex = {{(ACC_WIDTH-15){1'b0}}, ax};
            ey = {{(ACC_WIDTH-15){1'b0}}, ay};
        end else begin
            ex = {{(ACC_WIDTH-16){r_x[15]}}, r_x};
            ey = {{(ACC_WIDTH-16){r_y[15]}}, r_y};
        end

        // last absolute position after a flush of the old pending report
        mid_x = (flush_old && !r_pend_rel) ? r_pend_dx[14:0] : r_last_x;
        mid_y = (flush_old && !r_pend_rel) ? r_pend_dy[14:0] : r_last_y;

        n_pend_valid = r_pend_valid;
        n_pend_rel   = r_pend_rel;
        n_pend_btn   = r_pend_btn;
        n_pend_dx    = r_pend_dx;
        n_pend_dy    = r_pend_dy;
        n_pend_wh    = r_pend_wh;
        n_pend_pn    = r_pend_pn;
        n_last_x     = mid_x;
        n_last_y     = mid_y;

        has_first = flush_old;
        first = mouse_report(r_pend_rel, r_pend_btn, r_pend_dx, r_pend_dy,
                             r_pend_wh, r_pend_pn);
        for (int k = 0; k < 4; k++) begin
            own[k] = hrc_pkg::REPORT_ZERO;
        end
        own_cnt = '0;

        if (merge) begin
            if (r_pend_rel) begin
                n_pend_dx = sat_add(r_pend_dx, r_x);
                n_pend_dy = sat_add(r_pend_dy, r_y);
            end else begin
                n_pend_dx = ex;
                n_pend_dy = ey;
            end
            n_pend_wh = sat_scroll(r_pend_wh, r_wh);
            n_pend_pn = sat_scroll(r_pend_pn, r_pn);
            if (!r_more) begin
                n_pend_valid = 1'b0;
                has_first = 1'b1;
                first = mouse_report(r_pend_rel, r_pend_btn, n_pend_dx, n_pend_dy,
                                     n_pend_wh, n_pend_pn);
                if (!r_pend_rel) begin
                    n_last_x = n_pend_dx[14:0];
                    n_last_y = n_pend_dy[14:0];
                end
            end
        end else begin
            n_pend_valid = 1'b0;
            if (r_mounted) begin
                if (mouse) begin
                    n_pend_rel = r_mode[0];
                    n_pend_btn = r_btn;
                    n_pend_dx  = ex;
                    n_pend_dy  = ey;
                    n_pend_wh  = r_wh;
                    n_pend_pn  = r_pn;
                    if (r_more) begin
                        n_pend_valid = 1'b1;
                    end else begin
                        own[0]  = mouse_report(r_mode[0], r_btn, ex, ey, r_wh, r_pn);
                        own_cnt = 3'd1;
                        if (!r_mode[0]) begin
                            n_last_x = ax;
                            n_last_y = ay;
                        end
                    end
                end else begin
                    case (r_mode)
                        hrc_pkg::MODE_KEYB: begin
                            own[0].kind    = hrc_pkg::KIND_KEYB;
                            own[0].buttons = r_btn;
                            own[0].keys    = r_keys;
                            own_cnt        = 3'd1;
                        end
                        hrc_pkg::MODE_CONSUME: begin
                            own[0].kind  = hrc_pkg::KIND_CONSUME;
                            own[0].usage = r_usage;
                            own_cnt      = 3'd1;
                        end
                        hrc_pkg::MODE_RELEASE: begin
                            own[0].kind = hrc_pkg::KIND_KEYB;
                            own[1].kind = hrc_pkg::KIND_CONSUME;
                            own[2].kind = hrc_pkg::KIND_REL;
                            own[3].kind = hrc_pkg::KIND_ABS;
                            own[3].x    = {1'b0, mid_x};
                            own[3].y    = {1'b0, mid_y};
                            own_cnt     = 3'd4;
                        end
                        default: begin
                            own_cnt = '0;
                        end
                    endcase
                end
            end
        end

        // flush report first, then the event's own reports
        n_list[0] = has_first ? first : own[0];
        for (int k = 1; k < 4; k++) begin
            n_list[k] = has_first ? own[k-1] : own[k];
        end
        n_list[4] = has_first ? own[3] : hrc_pkg::REPORT_ZERO;
        n_cnt = CNT_W'(own_cnt) + CNT_W'(has_first);
    end

    // ---------------------------------------------------------------- clocked

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_max    <= hrc_pkg::ABS_MAX_RESET;
            r_in_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_pend_rel   <= 1'b0;
            r_pend_btn   <= '0;
            r_pend_dx    <= '0;
            r_pend_dy    <= '0;
            r_pend_wh    <= '0;
            r_pend_pn    <= '0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_abs_max <= i_cfg_wdata;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_pend_valid <= n_pend_valid;
                r_pend_rel   <= n_pend_rel;
                r_pend_btn   <= n_pend_btn;
                r_pend_dx    <= n_pend_dx;
                r_pend_dy    <= n_pend_dy;
                r_pend_wh    <= n_pend_wh;
                r_pend_pn    <= n_pend_pn;
                r_last_x     <= n_last_x;
                r_last_y     <= n_last_y;
                r_cnt        <= n_cnt;
            end else if (take) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mode    <= i_mode;
            r_btn     <= i_buttons_or_modifier;
            r_x       <= i_pos_x;
            r_y       <= i_pos_y;
            r_wh      <= i_wheel;
            r_pn      <= i_pan;
            r_keys    <= i_key_codes;
            r_usage   <= i_usage_code;
            r_more    <= i_more_queued;
            r_mounted <= i_host_mounted;
        end
    end

    // report list, head at entry 0
    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int k = 0; k < hrc_pkg::MAX_REPORTS; k++) begin
                r_list[k] <= n_list[k];
            end
        end else if (take) begin
            for (int k = 0; k < hrc_pkg::MAX_REPORTS - 1; k++) begin
                r_list[k] <= r_list[k+1];
            end
        end
    end

    // ---------------------------------------------------------------- outputs

    assign o_valid       = (r_cnt != '0);
    assign o_report_kind = r_list[0].kind;
    assign o_out_buttons = r_list[0].buttons;
    assign o_out_x       = r_list[0].x;
    assign o_out_y       = r_list[0].y;
    assign o_out_wheel   = r_list[0].wheel;
    assign o_out_pan     = r_list[0].pan;
    assign o_out_keys    = r_list[0].keys;
    assign o_out_usage   = r_list[0].usage;
    assign o_last_of_run = (r_cnt == CNT_W'(1));

endmodule
